### sv/tlvp_pkg.sv
// Shared types and constants of the BER-TLV header parser.
package tlvp_pkg;

	localparam int unsigned DATA_W   = 8;
	localparam int unsigned TAG_W    = 16;
	localparam int unsigned LEN_W    = 24;
	localparam int unsigned TDATA_W  = 56;
	localparam int unsigned TUSER_W  = 2;

	// Parser phases.
	localparam logic [2:0] PH_TAG1  = 3'd0;
	localparam logic [2:0] PH_TAG2  = 3'd1;
	localparam logic [2:0] PH_LEN1  = 3'd2;
	localparam logic [2:0] PH_LENX  = 3'd3;
	localparam logic [2:0] PH_VALUE = 3'd4;
	localparam logic [2:0] PH_SKIP  = 3'd5;

	// Result kinds.
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_VALUE  = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// Error status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TRUNC     = 2'd1;
	localparam logic [1:0] ST_NONMIN    = 2'd2;
	localparam logic [1:0] ST_UNSUP     = 2'd3;

	// Tag and length encoding constants.
	localparam logic [4:0]       TAG_MULTI  = 5'h1f;
	localparam logic [7:0]       LEN_LONG1  = 8'h81;
	localparam logic [7:0]       LEN_LONG2  = 8'h82;
	localparam logic [7:0]       LEN_LONG3  = 8'h83;
	localparam logic [LEN_W-1:0] LEN_MIN1   = 24'h000080;
	localparam logic [LEN_W-1:0] LEN_MIN2   = 24'h000100;
	localparam logic [LEN_W-1:0] LEN_MIN3   = 24'h010000;

	typedef struct packed {
		logic [2:0]       phase;
		logic [TAG_W-1:0] tag_hold;
		logic [1:0]       length_bytes_left;
		logic [1:0]       length_form;
		logic [LEN_W-1:0] length_accum;
		logic [LEN_W-1:0] value_left;
	} parse_state_t;

	typedef struct packed {
		logic [1:0]        result_kind;
		logic [TAG_W-1:0]  tag_value;
		logic [LEN_W-1:0]  length_value;
		logic [DATA_W-1:0] value_byte;
		logic [1:0]        status;
		logic              truncated;
		logic              last;
	} result_t;

endpackage

### sv/ber_tlv_header_parser.sv
// Top level of the BER-TLV header parser: input register, parser state, result register.
//
// Usage:
//   The slave stream carries one byte of an encoded string per transaction in
//   s_axis_tdata, with s_axis_tlast on the final byte of the string. The block
//   parses the leading record of each string and sends at most one result per
//   input byte on the master stream: a header (tag and length), a value byte,
//   or an error. m_axis_tuser gives the result kind, m_axis_tlast marks the
//   final result of the record. Bytes after the record or after an error are
//   dropped until the end of the string.
// Flow:
//   The accepting edge loads the byte into the input register. When the result
//   register is free, the parser logic then updates the state and loads the
//   result register. One byte is taken every cycle while the master stream
//   does not stall.
// Reset:
//   arst_n clears the valid flags of both registers and the parser state; the
//   block then expects the first tag byte of a new string.
// Stall:
//   While the result register holds an untaken result and m_axis_tready is
//   low, the input register stops and s_axis_tready drops once it is full.
module ber_tlv_header_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [tlvp_pkg::DATA_W-1:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic                         s_axis_tlast,  // end_of_data
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// [15:0] tag_value, [39:16] length_value, [47:40] value_byte,
	// [49:48] status, [50] truncated, [55:51] zero
	output logic [tlvp_pkg::TDATA_W-1:0] m_axis_tdata,
	output logic [tlvp_pkg::TUSER_W-1:0] m_axis_tuser,  // [1:0] result_kind
	output logic                         m_axis_tlast   // last
);
	import tlvp_pkg::*;

	logic              in_valid_s1;
	logic [DATA_W-1:0] in_byte_s1;
	logic              in_eod_s1;
	parse_state_t      state_q;
	parse_state_t      state_nxt;
	logic              res_valid;
	result_t           res;
	logic              out_valid_q;
	result_t           out_q;
	logic              out_free;
	logic              advance;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = in_valid_s1 && out_free;
	assign s_axis_tready = !in_valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			in_byte_s1 <= s_axis_tdata;
			in_eod_s1  <= s_axis_tlast;
		end
	end

	tlvp_step u_step (
		.st          (state_q),
		.data_byte   (in_byte_s1),
		.end_of_data (in_eod_s1),
		.nxt         (state_nxt),
		.res_valid   (res_valid),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.result_kind;
	assign m_axis_tlast  = out_q.last;
	assign m_axis_tdata  = {5'b0, out_q.truncated, out_q.status, out_q.value_byte,
		out_q.length_value, out_q.tag_value};

endmodule

### sv/tlvp_step.sv
// Next-state and result logic for one input byte of the parser.
module tlvp_step (
	input  tlvp_pkg::parse_state_t    st,
	input  logic [tlvp_pkg::DATA_W-1:0] data_byte,
	input  logic                      end_of_data,
	output tlvp_pkg::parse_state_t    nxt,
	output logic                      res_valid,
	output tlvp_pkg::result_t         res
);
	import tlvp_pkg::*;

	logic             do_err;
	logic [1:0]       err_code;
	logic             do_hdr;
	logic [LEN_W-1:0] hdr_len;
	logic [LEN_W-1:0] acc_new;
	logic [1:0]       left_new;
	logic [LEN_W-1:0] val_new;
	logic             below_min;

	always_comb begin
		nxt       = st;
		res       = '0;
		res_valid = 1'b0;
		do_err    = 1'b0;
		err_code  = ST_OK;
		do_hdr    = 1'b0;
		hdr_len   = '0;
		acc_new   = {st.length_accum[LEN_W-DATA_W-1:0], data_byte};
		left_new  = st.length_bytes_left - 2'd1;
		val_new   = st.value_left - {{(LEN_W-1){1'b0}}, 1'b1};
		unique case (st.length_form)
			2'd1:    below_min = acc_new < LEN_MIN1;
			2'd2:    below_min = acc_new < LEN_MIN2;
			default: below_min = acc_new < LEN_MIN3;
		endcase

		unique case (st.phase)
			PH_TAG2: begin
				nxt.tag_hold = {st.tag_hold[DATA_W-1:0], data_byte};
				if (end_of_data) begin
					do_err   = 1'b1;
					err_code = ST_TRUNC;
				end else begin
					nxt.phase = PH_LEN1;
				end
			end
			PH_LEN1: begin
				if (!data_byte[DATA_W-1]) begin
					do_hdr  = 1'b1;
					hdr_len = {{(LEN_W-DATA_W){1'b0}}, data_byte};
				end else if (data_byte == LEN_LONG1 || data_byte == LEN_LONG2 ||
						data_byte == LEN_LONG3) begin
					nxt.length_form       = data_byte[1:0];
					nxt.length_bytes_left = data_byte[1:0];
					nxt.length_accum      = '0;
					if (end_of_data) begin
						do_err   = 1'b1;
						err_code = ST_TRUNC;
					end else begin
						nxt.phase = PH_LENX;
					end
				end else begin
					do_err   = 1'b1;
					err_code = ST_UNSUP;
				end
			end
			PH_LENX: begin
				nxt.length_accum      = acc_new;
				nxt.length_bytes_left = left_new;
				if (left_new != 2'd0) begin
					if (end_of_data) begin
						do_err   = 1'b1;
						err_code = ST_TRUNC;
					end
				end else if (below_min) begin
					do_err   = 1'b1;
					err_code = ST_NONMIN;
				end else begin
					do_hdr  = 1'b1;
					hdr_len = acc_new;
				end
			end
			PH_VALUE: begin
				res_valid       = 1'b1;
				res.result_kind = KIND_VALUE;
				res.value_byte  = data_byte;
				nxt.value_left  = val_new;
				if (val_new == '0) begin
					res.last  = 1'b1;
					nxt.phase = end_of_data ? PH_TAG1 : PH_SKIP;
				end else if (end_of_data) begin
					res.truncated = 1'b1;
					res.last      = 1'b1;
					nxt.phase     = PH_TAG1;
				end
			end
			PH_SKIP: begin
				if (end_of_data) begin
					nxt.phase = PH_TAG1;
				end
			end
			default: begin
				// First tag byte; unused phase codes land here as well.
				nxt.tag_hold = {{(TAG_W-DATA_W){1'b0}}, data_byte};
				if (end_of_data) begin
					do_err   = 1'b1;
					err_code = ST_TRUNC;
				end else if (data_byte[4:0] == TAG_MULTI) begin
					nxt.phase = PH_TAG2;
				end else begin
					nxt.phase = PH_LEN1;
				end
			end
		endcase

		if (do_err) begin
			res_valid       = 1'b1;
			res.result_kind = KIND_ERROR;
			res.status      = err_code;
			res.last        = 1'b1;
			nxt.phase       = end_of_data ? PH_TAG1 : PH_SKIP;
		end

		if (do_hdr) begin
			res_valid        = 1'b1;
			res.result_kind  = KIND_HEADER;
			res.tag_value    = st.tag_hold;
			res.length_value = hdr_len;
			if (hdr_len == '0) begin
				res.last  = 1'b1;
				nxt.phase = end_of_data ? PH_TAG1 : PH_SKIP;
			end else if (end_of_data) begin
				res.truncated = 1'b1;
				res.last      = 1'b1;
				nxt.phase     = PH_TAG1;
			end else begin
				nxt.value_left = hdr_len;
				nxt.phase      = PH_VALUE;
			end
		end
	end

endmodule

### sv/tlvp_checker.sv
// Port-level checks of the BER-TLV header parser, bound to its top level.
module tlvp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         m_axis_tvalid,
	input logic                         m_axis_tready,
	input logic [tlvp_pkg::TDATA_W-1:0] m_axis_tdata,
	input logic [tlvp_pkg::TUSER_W-1:0] m_axis_tuser,
	input logic                         m_axis_tlast
);
	import tlvp_pkg::*;

	// A stalled result stays on offer.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// Only the three defined kinds are ever sent.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser != 2'd3)
		else $error("undefined result kind");

	// An error ends the record, carries a nonzero status and is never truncated.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_ERROR |->
		m_axis_tlast && !m_axis_tdata[50] && m_axis_tdata[49:48] != ST_OK)
		else $error("malformed error result");

	// Headers and value bytes carry status ok.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != KIND_ERROR |-> m_axis_tdata[49:48] == ST_OK)
		else $error("status set on non-error result");

	// A truncated result is always the last of its record.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[50] |-> m_axis_tlast)
		else $error("truncated result without last");

endmodule

bind ber_tlv_header_parser tlvp_checker u_tlvp_checker (.*);
